// ----- rtl/core/aes_rpu_pkg.sv -----
// Shared types, constants and GF(2^8) helpers for the AES round primitive unit.
// Depends on nothing; every module of the unit imports it.
`timescale 1ns / 1ps

package aes_rpu_pkg;

	typedef enum logic [3:0] {
		CMD_SUB_FWD    = 4'd0,
		CMD_SUB_INV    = 4'd1,
		CMD_SHIFT_FWD  = 4'd2,
		CMD_SHIFT_INV  = 4'd3,
		CMD_MIX_FWD    = 4'd4,
		CMD_MIX_INV    = 4'd5,
		CMD_HSHIFT_FWD = 4'd6,
		CMD_HSHIFT_INV = 4'd7,
		CMD_SBOX8_FWD  = 4'd8,
		CMD_SBOX8_INV  = 4'd9,
		CMD_SUBW_FWD   = 4'd10,
		CMD_SUBW_INV   = 4'd11,
		CMD_ROTWORD    = 4'd12,
		CMD_RCON       = 4'd13,
		CMD_MIXB_FWD   = 4'd14,
		CMD_MIXB_INV   = 4'd15
	} cmd_t;

	localparam int STATE_W = 128;
	localparam int RCON_N  = 10;
	localparam logic [7:0] POLY_LOW = 8'h1B;

	// Stage-2 payload: command, state, S-box outputs, shifted state, RotWord,
	// round constant and the xtime powers of every state byte, handed to the combine stage.
	typedef struct packed {
		cmd_t               cmd;
		logic [STATE_W-1:0] st;
		logic [STATE_W-1:0] sub;
		logic [STATE_W-1:0] shifted;
		logic [STATE_W-1:0] x2;
		logic [STATE_W-1:0] x4;
		logic [STATE_W-1:0] x8;
		logic [31:0]        rot;
		logic [7:0]         rcon;
	} lookup_t;

	localparam logic [7:0] RCON_TAB [RCON_N] = '{
		8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1B, 8'h36
	};

	localparam logic [3:0] MIX_FWD_K [4] = '{4'd2, 4'd3, 4'd1, 4'd1};
	localparam logic [3:0] MIX_INV_K [4] = '{4'd14, 4'd11, 4'd13, 4'd9};

	localparam logic [7:0] FWD_SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] INV_SBOX [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	// Multiply by x in GF(2^8).
	function automatic logic [7:0] xtime(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? POLY_LOW : 8'h00);
	endfunction

	// Product with a 4-bit constant, built from precomputed x, 2x, 4x, 8x.
	function automatic logic [7:0] gmul_k(input logic [7:0] x1, input logic [7:0] x2,
			input logic [7:0] x4, input logic [7:0] x8, input logic [3:0] k);
		return (k[0] ? x1 : 8'h00) ^ (k[1] ? x2 : 8'h00) ^
			(k[2] ? x4 : 8'h00) ^ (k[3] ? x8 : 8'h00);
	endfunction

	// Byte 4c+r of the result comes from column c+r (forward) or c-r (inverse).
	function automatic logic [STATE_W-1:0] shift_rows(input logic [STATE_W-1:0] s,
			input logic inv);
		logic [STATE_W-1:0] t;
		logic [1:0]         src;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				src = inv ? 2'(c - r) : 2'(c + r);
				t[8*(4*c+r) +: 8] = s[8*(4*int'(src)+r) +: 8];
			end
		end
		return t;
	endfunction

endpackage

// ----- rtl/core/aes_rpu_lookup.sv -----
// Second pipeline stage: S-box lookups, ShiftRows, RotWord, round constant
// and xtime powers of every state byte. Depends on aes_rpu_pkg.
`timescale 1ns / 1ps

module aes_rpu_lookup import aes_rpu_pkg::*; (
	input  logic               clk,
	input  logic               load,
	input  cmd_t               cmd,
	input  logic [STATE_W-1:0] st,
	output lookup_t            lookup_s2
);

	lookup_t nxt;
	logic    inv;

	assign inv = cmd[0];

	always_comb begin
		nxt.cmd     = cmd;
		nxt.st      = st;
		nxt.shifted = shift_rows(st, inv);
		nxt.rot     = {st[7:0], st[31:8]};
		nxt.rcon    = (st[7:0] < 8'(RCON_N)) ? RCON_TAB[st[3:0]] : 8'h00;
		for (int i = 0; i < STATE_W/8; i++) begin
			nxt.sub[8*i +: 8] = inv ? INV_SBOX[st[8*i +: 8]] : FWD_SBOX[st[8*i +: 8]];
			nxt.x2[8*i +: 8]  = xtime(st[8*i +: 8]);
			nxt.x4[8*i +: 8]  = xtime(xtime(st[8*i +: 8]));
			nxt.x8[8*i +: 8]  = xtime(xtime(xtime(st[8*i +: 8])));
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			lookup_s2 <= nxt;
		end
	end

endmodule

// ----- rtl/core/aes_rpu_combine.sv -----
// Third pipeline stage: MixColumns xor network, single-byte MixColumn and
// the final result select with zero fill. Depends on aes_rpu_pkg.
`timescale 1ns / 1ps

module aes_rpu_combine import aes_rpu_pkg::*; (
	input  logic               clk,
	input  logic               load,
	input  lookup_t            lookup_s2,
	output logic [STATE_W-1:0] result_s3
);

	logic [STATE_W-1:0] mix;
	logic [STATE_W-1:0] res;
	logic [3:0]         k;
	logic [7:0]         acc;
	logic [7:0]         b1, b2, b4, b8;

	assign b1 = lookup_s2.st[7:0];
	assign b2 = lookup_s2.x2[7:0];
	assign b4 = lookup_s2.x4[7:0];
	assign b8 = lookup_s2.x8[7:0];

	always_comb begin
		mix = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				acc = 8'h00;
				for (int j = 0; j < 4; j++) begin
					k = (lookup_s2.cmd == CMD_MIX_INV) ? MIX_INV_K[2'(j - r)]
						: MIX_FWD_K[2'(j - r)];
					acc = acc ^ gmul_k(lookup_s2.st[8*(4*c+j) +: 8],
						lookup_s2.x2[8*(4*c+j) +: 8], lookup_s2.x4[8*(4*c+j) +: 8],
						lookup_s2.x8[8*(4*c+j) +: 8], k);
				end
				mix[8*(4*c+r) +: 8] = acc;
			end
		end
	end

	always_comb begin
		unique case (lookup_s2.cmd)
			CMD_SUB_FWD, CMD_SUB_INV:       res = lookup_s2.sub;
			CMD_SHIFT_FWD, CMD_SHIFT_INV:   res = lookup_s2.shifted;
			CMD_MIX_FWD, CMD_MIX_INV:       res = mix;
			CMD_HSHIFT_FWD, CMD_HSHIFT_INV: res = {64'h0, lookup_s2.shifted[63:0]};
			CMD_SBOX8_FWD, CMD_SBOX8_INV:   res = {64'h0, lookup_s2.sub[63:0]};
			CMD_SUBW_FWD, CMD_SUBW_INV:     res = {96'h0, lookup_s2.sub[31:0]};
			CMD_ROTWORD:                    res = {96'h0, lookup_s2.rot};
			CMD_RCON:                       res = {120'h0, lookup_s2.rcon};
			CMD_MIXB_FWD:                   res = {96'h0, b2 ^ b1, b1, b1, b2};
			CMD_MIXB_INV:                   res = {96'h0, b8 ^ b2 ^ b1, b8 ^ b4 ^ b1,
				b8 ^ b1, b8 ^ b4 ^ b2};
			default:                        res = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_s3 <= res;
		end
	end

endmodule

// ----- rtl/core/aes_round_primitive_unit.sv -----
// AES round primitive unit: three-stage pipeline wrapping the lookup and
// combine stages. Depends on aes_rpu_pkg, aes_rpu_lookup, aes_rpu_combine.
`timescale 1ns / 1ps

// Usage:
//  - Input channel s_axis_*: one operation per transfer; tuser carries the
//    command, tdata the 128-bit state (or rs1/rs2, or a narrow operand in the
//    low bits). Output channel m_axis_*: one 128-bit result per operation,
//    in the order the operations were taken.
//  - Path: a taken transfer lands in the input register, then in the lookup
//    register and then in the result register, and m_axis_tvalid rises once
//    the result register holds it.
//  - Throughput: one operation every cycle while m_axis_tready is high. The
//    rate is fixed by the three register stages: the S-box tables sit in the
//    second stage and the MixColumns xor network in the third, each one stage deep.
//  - Stall: when m_axis_tready is low the result holds; each stage advances
//    only into an empty slot or one that empties in the same cycle, so all
//    three stages fill before s_axis_tready drops. Nothing is dropped or
//    issued twice.
//  - Reset: arst_n clears the stage valid bits at once; the pipeline comes up
//    empty with s_axis_tready high. The data registers are not reset.
module aes_round_primitive_unit import aes_rpu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [STATE_W-1:0] s_axis_tdata,  // [63:0] operand_low, [127:64] operand_high
	input  logic [3:0]         s_axis_tuser,  // [3:0] cmd
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [STATE_W-1:0] m_axis_tdata   // [63:0] result_low, [127:64] result_high
);

	logic               valid_s1, valid_s2, valid_s3;
	logic               adv1, adv2, adv3;
	cmd_t               cmd_s1;
	logic [STATE_W-1:0] state_s1;
	lookup_t            lookup_s2;
	logic [STATE_W-1:0] result_s3;

	// Advance a stage when it is empty or its content moves on this cycle.
	assign adv3 = !valid_s3 || m_axis_tready;
	assign adv2 = !valid_s2 || adv3;
	assign adv1 = !valid_s1 || adv2;

	assign s_axis_tready = adv1;
	assign m_axis_tvalid = valid_s3;
	assign m_axis_tdata  = result_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv1) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
			if (adv3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// Capture the operation on each input transfer.
	always_ff @(posedge clk) begin
		if (adv1 && s_axis_tvalid) begin
			cmd_s1   <= cmd_t'(s_axis_tuser);
			state_s1 <= s_axis_tdata;
		end
	end

	aes_rpu_lookup u_lookup (
		.clk       (clk),
		.load      (adv2 && valid_s1),
		.cmd       (cmd_s1),
		.st        (state_s1),
		.lookup_s2 (lookup_s2)
	);

	aes_rpu_combine u_combine (
		.clk       (clk),
		.load      (adv3 && valid_s2),
		.lookup_s2 (lookup_s2),
		.result_s3 (result_s3)
	);

`ifndef SYNTHESIS
	// Input backpressure only when every stage holds an operation.
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && valid_s2 && valid_s3))
		else $error("input stalled with a free pipeline slot");

	// An operation in stage 1 that advances must show up in stage 2.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv2) |=> valid_s2)
		else $error("operation lost between stage 1 and stage 2");

	// Narrow operations leave the upper result half zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && adv3 && (lookup_s2.cmd >= CMD_HSHIFT_FWD))
		|=> (m_axis_tdata[127:64] == 64'h0))
		else $error("upper result half not cleared for a narrow operation");
`endif

endmodule
